FILE: sv/pdpat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpat_pkg
// Shared types, widths and constants for the PD position to attitude/thrust
// pipeline.
// ----------------------------------------------------------------------------
package pdpat_pkg;

    // Field widths
    localparam int POS_W    = 32;
    localparam int ATT_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int CFG_A_W  = 4;
    localparam int CFG_D_W  = 32;

    // Datapath widths
    localparam int E_W      = POS_W + 1;      // position / velocity error
    localparam int PR_W     = 50;             // gain times error
    localparam int U_W      = 52;             // command, Q.24
    localparam int M_W      = 51;             // command magnitude
    localparam int VM_W     = 30;             // block-scaled magnitude
    localparam int VS_W     = VM_W + 1;       // block-scaled signed value
    localparam int A_W      = 26;             // thrust axis, Q.20
    localparam int AX_W     = 36;             // axis before rounding, Q.28
    localparam int P_W      = 57;             // axis times command
    localparam int Q_W      = 58;             // raw quaternion component
    localparam int QM_W     = Q_W - 1;        // raw quaternion magnitude
    localparam int SH_W     = 5;              // block-scale shift
    localparam int SQ_W     = 2 * VM_W;       // one square
    localparam int SQ_IN_W  = 62;             // radicand
    localparam int SQ_OUT_W = 31;             // root
    localparam int SQRT_STG = 31;             // one root bit per stage
    localparam int PROD_W   = 49;             // root times mass
    localparam int THR_W    = 32;
    localparam int QUO_W    = 15;             // quotient bits
    localparam int DIV_STG  = QUO_W;
    localparam int DIV_W    = 46;             // divider remainder
    localparam int FRAC_Q   = 14;             // Q1.14 output scale
    localparam int N_SHIFT  = 20;             // root into Q.20 axis scale
    localparam int U_FRAC   = 24;             // command fraction bits

    // Pipeline latency in register stages, accept to result
    localparam int PIPE_LAT = 2 * SQRT_STG + DIV_STG + 16;

    // Constants
    localparam logic signed [U_W-1:0] G_Q24   = U_W'(164416717);  // 9.8 in Q.24
    localparam logic [17:0]           MASS_Q16 = 18'd187171;      // 2.856 in Q.16
    localparam logic [GAIN_W-1:0]     KP_RST  = 16'd810;
    localparam logic [GAIN_W-1:0]     KD_RST  = 16'd693;
    localparam logic signed [16:0]    OUT_MAX = 17'sd16384;

    // Configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_KP_GAIN   = 4'd0,
        CFG_KD_GAIN   = 4'd1,
        CFG_REF_POS_X = 4'd2,
        CFG_REF_POS_Y = 4'd3,
        CFG_REF_POS_Z = 4'd4,
        CFG_REF_VEL_X = 4'd5,
        CFG_REF_VEL_Y = 4'd6,
        CFG_REF_VEL_Z = 4'd7
    } t_cfg_idx;

    // Input beat
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic signed [POS_W-1:0] vel_z;
        logic signed [ATT_W-1:0] att_w;
        logic signed [ATT_W-1:0] att_x;
        logic signed [ATT_W-1:0] att_y;
        logic signed [ATT_W-1:0] att_z;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic signed [ATT_W-1:0] des_w;
        logic signed [ATT_W-1:0] des_x;
        logic signed [ATT_W-1:0] des_y;
        logic signed [ATT_W-1:0] des_z;
        logic [THR_W-1:0]        thrust_force;
    } t_out_beat;

    // Side data carried through the first root unit
    typedef struct packed {
        logic signed [Q_W-1:0] dot;
        logic signed [Q_W-1:0] q1;
        logic signed [Q_W-1:0] q2;
        logic signed [Q_W-1:0] q3;
        logic [SH_W-1:0]       sh;
    } t_side1;

    // Side data carried through the second root unit
    typedef struct packed {
        logic [3:0][VM_W-1:0] qm;
        logic [3:0]           neg;
        logic [THR_W-1:0]     thr;
    } t_side2;

endpackage

FILE: sv/pd_position_to_attitude_thrust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_position_to_attitude_thrust
// PD position controller: desired attitude quaternion and thrust magnitude
// from NED position, velocity and attitude.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a beat is taken at each rising edge with start high and
//   busy low. busy stays low, so a new beat can enter in every cycle.
//   Result channel: o_valid is high for one cycle with the result on o_out;
//   the receiver takes it in that cycle and cannot hold it off.
//   The latency from the accepting edge to the edge that takes the result
//   is pdpat_pkg::PIPE_LAT. Throughput is one beat per cycle.
//   The depth comes from the two root units (31 stages each, one root bit a
//   stage) and the divider (15 stages, one quotient bit a stage, four lanes).
//   Configuration: a write to i_cfg_addr with i_cfg_we high updates one gain
//   or reference at that edge; write only while no beat is in flight.
//   Reset: clears every valid bit, so nothing in flight comes out, and loads
//   the gains and references with their reset values.
// ----------------------------------------------------------------------------
module pd_position_to_attitude_thrust (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  pdpat_pkg::t_in_beat                  i_in,
    output logic                                 o_valid,
    output pdpat_pkg::t_out_beat                 o_out,
    input  logic                                 i_cfg_we,
    input  logic [pdpat_pkg::CFG_A_W-1:0]        i_cfg_addr,
    input  logic [pdpat_pkg::CFG_D_W-1:0]        i_cfg_data
);

    localparam int POS_W  = pdpat_pkg::POS_W;
    localparam int E_W    = pdpat_pkg::E_W;
    localparam int PR_W   = pdpat_pkg::PR_W;
    localparam int U_W    = pdpat_pkg::U_W;
    localparam int M_W    = pdpat_pkg::M_W;
    localparam int VM_W   = pdpat_pkg::VM_W;
    localparam int VS_W   = pdpat_pkg::VS_W;
    localparam int A_W    = pdpat_pkg::A_W;
    localparam int AX_W   = pdpat_pkg::AX_W;
    localparam int P_W    = pdpat_pkg::P_W;
    localparam int Q_W    = pdpat_pkg::Q_W;
    localparam int QM_W   = pdpat_pkg::QM_W;
    localparam int SH_W   = pdpat_pkg::SH_W;
    localparam int SQ_W   = pdpat_pkg::SQ_W;
    localparam int RAD_W  = pdpat_pkg::SQ_IN_W;
    localparam int RT_W   = pdpat_pkg::SQ_OUT_W;
    localparam int PROD_W = pdpat_pkg::PROD_W;
    localparam int THR_W  = pdpat_pkg::THR_W;
    localparam int QUO_W  = pdpat_pkg::QUO_W;
    localparam int DSTG   = pdpat_pkg::DIV_STG;
    localparam int DIV_W  = pdpat_pkg::DIV_W;
    localparam int ATT_W  = pdpat_pkg::ATT_W;
    localparam int SIDE1_W = $bits(pdpat_pkg::t_side1);
    localparam int SIDE2_W = $bits(pdpat_pkg::t_side2);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pdpat_pkg::GAIN_W-1:0] r_kp;
    logic [pdpat_pkg::GAIN_W-1:0] r_kd;
    logic signed [POS_W-1:0]      r_ref_pos [0:2];
    logic signed [POS_W-1:0]      r_ref_vel [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= pdpat_pkg::KP_RST;
            r_kd <= pdpat_pkg::KD_RST;
            for (int i = 0; i < 3; i++) begin
                r_ref_pos[i] <= '0;
                r_ref_vel[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (pdpat_pkg::t_cfg_idx'(i_cfg_addr))
                pdpat_pkg::CFG_KP_GAIN:   r_kp <= i_cfg_data[pdpat_pkg::GAIN_W-1:0];
                pdpat_pkg::CFG_KD_GAIN:   r_kd <= i_cfg_data[pdpat_pkg::GAIN_W-1:0];
                pdpat_pkg::CFG_REF_POS_X: r_ref_pos[0] <= i_cfg_data;
                pdpat_pkg::CFG_REF_POS_Y: r_ref_pos[1] <= i_cfg_data;
                pdpat_pkg::CFG_REF_POS_Z: r_ref_pos[2] <= i_cfg_data;
                pdpat_pkg::CFG_REF_VEL_X: r_ref_vel[0] <= i_cfg_data;
                pdpat_pkg::CFG_REF_VEL_Y: r_ref_vel[1] <= i_cfg_data;
                pdpat_pkg::CFG_REF_VEL_Z: r_ref_vel[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld;
    logic r9_vld, r10_vld, r11_vld, r12_vld, r13_vld, r14_vld, r15_vld;
    logic [DSTG-1:0] r_dvld;
    logic            r_ovld;

    // stage 1: errors and attitude products
    logic signed [E_W-1:0]  n1_ep [0:2], n1_ev [0:2], r1_ep [0:2], r1_ev [0:2];
    logic signed [31:0]     n1_pxz, n1_pwy, n1_pyz, n1_pwx, n1_pxx, n1_pyy;
    logic signed [31:0]     r1_pxz, r1_pwy, r1_pyz, r1_pwx, r1_pxx, r1_pyy;
    // stage 2: gain products and thrust axis
    logic signed [PR_W-1:0] n2_pk [0:2], n2_dk [0:2], r2_pk [0:2], r2_dk [0:2];
    logic signed [A_W-1:0]  n2_a [0:2], r2_a [0:2];
    // stage 3: command
    logic signed [U_W-1:0]  n3_u [0:2], r3_u [0:2];
    logic signed [A_W-1:0]  r3_a [0:2];
    // stage 4: magnitudes
    logic [M_W-1:0]         n4_m [0:2], r4_m [0:2];
    logic [2:0]             n4_neg, r4_neg;
    logic signed [A_W-1:0]  r4_a [0:2];
    // stage 5: block-scale shift
    logic [SH_W-1:0]        n5_sh, r5_sh;
    logic [M_W-1:0]         r5_m [0:2];
    logic [2:0]             r5_neg;
    logic signed [A_W-1:0]  r5_a [0:2];
    // stage 6: scaled command
    logic [VM_W-1:0]        n6_vm [0:2], r6_vm [0:2];
    logic signed [VS_W-1:0] n6_vs [0:2], r6_vs [0:2];
    logic [SH_W-1:0]        r6_sh;
    logic signed [A_W-1:0]  r6_a [0:2];
    // stage 7: squares and axis products
    logic [SQ_W-1:0]        n7_sq [0:2], r7_sq [0:2];
    logic signed [P_W-1:0]  n7_p [0:2][0:2], r7_p [0:2][0:2];
    logic [SH_W-1:0]        r7_sh;
    // stage 8: radicand and raw quaternion parts
    logic [RAD_W-1:0]       n8_rad, r8_rad;
    pdpat_pkg::t_side1      n8_side, r8_side;
    // first root unit
    logic                   s1_vld;
    logic [RT_W-1:0]        s1_root;
    logic [SIDE1_W-1:0]     s1_side_v;
    pdpat_pkg::t_side1      s1_side;
    // stage 9: scalar part and mass product
    logic signed [Q_W-1:0]  n9_q [0:3], r9_q [0:3];
    logic [PROD_W-1:0]      n9_prod, r9_prod;
    logic [SH_W-1:0]        r9_sh;
    // stage 10: thrust and quaternion magnitudes
    logic [THR_W-1:0]       n10_thr, r10_thr;
    logic [QM_W-1:0]        n10_qm [0:3], r10_qm [0:3];
    logic [3:0]             n10_neg, r10_neg;
    // stage 11: second block-scale shift
    logic [SH_W-1:0]        n11_sh, r11_sh;
    logic [QM_W-1:0]        r11_qm [0:3];
    logic [3:0]             r11_neg;
    logic [THR_W-1:0]       r11_thr;
    // stage 12: scaled quaternion
    logic [VM_W-1:0]        n12_qs [0:3], r12_qs [0:3];
    logic [3:0]             r12_neg;
    logic [THR_W-1:0]       r12_thr;
    // stage 13: squares
    logic [SQ_W-1:0]        n13_sq [0:3], r13_sq [0:3];
    logic [VM_W-1:0]        r13_qs [0:3];
    logic [3:0]             r13_neg;
    logic [THR_W-1:0]       r13_thr;
    // stage 14: radicand
    logic [RAD_W-1:0]       n14_rad, r14_rad;
    pdpat_pkg::t_side2      n14_side, r14_side;
    // second root unit
    logic                   s2_vld;
    logic [RT_W-1:0]        s2_root;
    logic [SIDE2_W-1:0]     s2_side_v;
    pdpat_pkg::t_side2      s2_side;
    // stage 15: dividends
    logic [DIV_W-1:0]       n15_d [0:3], r15_d [0:3];
    logic [RT_W-1:0]        r15_nn;
    logic [3:0]             r15_neg;
    logic [THR_W-1:0]       r15_thr;
    // divider stages
    logic [DIV_W-1:0]       c_drem [0:DSTG][0:3];
    logic [QUO_W-1:0]       c_dquo [0:DSTG][0:3];
    logic [DIV_W-1:0]       n_drem [0:DSTG-1][0:3], r_drem [0:DSTG-1][0:3];
    logic [QUO_W-1:0]       n_dquo [0:DSTG-1][0:3], r_dquo [0:DSTG-1][0:3];
    logic [RT_W-1:0]        r_dnn  [0:DSTG-1];
    logic [3:0]             r_dneg [0:DSTG-1];
    logic [THR_W-1:0]       r_dthr [0:DSTG-1];
    // output
    pdpat_pkg::t_out_beat   n_out, r_out;

    // ------------------------------------------------------------------
    // Stage 1: form errors, attitude products
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [POS_W-1:0] pos [0:2];
        logic signed [POS_W-1:0] vel [0:2];
        pos[0] = i_in.pos_x; pos[1] = i_in.pos_y; pos[2] = i_in.pos_z;
        vel[0] = i_in.vel_x; vel[1] = i_in.vel_y; vel[2] = i_in.vel_z;
        for (int i = 0; i < 3; i++) begin
            n1_ep[i] = E_W'(pos[i]) - E_W'(r_ref_pos[i]);
            n1_ev[i] = E_W'(vel[i]) - E_W'(r_ref_vel[i]);
        end
        n1_pxz = i_in.att_x * i_in.att_z;
        n1_pwy = i_in.att_w * i_in.att_y;
        n1_pyz = i_in.att_y * i_in.att_z;
        n1_pwx = i_in.att_w * i_in.att_x;
        n1_pxx = i_in.att_x * i_in.att_x;
        n1_pyy = i_in.att_y * i_in.att_y;
    end

    // ------------------------------------------------------------------
    // Stage 2: apply gains, round the thrust axis to Q.20
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [AX_W-1:0] t_ax, t_ay, t_az;
        for (int i = 0; i < 3; i++) begin
            n2_pk[i] = $signed({1'b0, r_kp}) * r1_ep[i];
            n2_dk[i] = $signed({1'b0, r_kd}) * r1_ev[i];
        end
        t_ax = -((AX_W'(r1_pxz) + AX_W'(r1_pwy)) <<< 1);
        t_ay = -((AX_W'(r1_pyz) - AX_W'(r1_pwx)) <<< 1);
        t_az = ((AX_W'(r1_pxx) + AX_W'(r1_pyy)) <<< 1) - (AX_W'(1) <<< 28);
        n2_a[0] = A_W'((t_ax + AX_W'(128)) >>> 8);
        n2_a[1] = A_W'((t_ay + AX_W'(128)) >>> 8);
        n2_a[2] = A_W'((t_az + AX_W'(128)) >>> 8);
    end

    // ------------------------------------------------------------------
    // Stage 3: command u, gravity on the down axis
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_u[i] = -U_W'(r2_pk[i]) - U_W'(r2_dk[i]);
        end
        n3_u[2] = n3_u[2] - pdpat_pkg::G_Q24;
    end

    // ------------------------------------------------------------------
    // Stage 4: split command into sign and magnitude
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_neg[i] = r3_u[i][U_W-1];
            n4_m[i]   = r3_u[i][U_W-1] ? M_W'(-r3_u[i]) : M_W'(r3_u[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: least shift that brings every magnitude below 2^30
    // ------------------------------------------------------------------
    always_comb begin
        logic [M_W-1:0] or_m;
        or_m  = r4_m[0] | r4_m[1] | r4_m[2];
        n5_sh = '0;
        for (int b = VM_W; b < M_W; b++) begin
            if (or_m[b]) n5_sh = SH_W'(b - VM_W + 1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: scale, truncating toward zero
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_vm[i] = VM_W'(r5_m[i] >> r5_sh);
            n6_vs[i] = r5_neg[i] ? -$signed({1'b0, n6_vm[i]}) : $signed({1'b0, n6_vm[i]});
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: squares of the scaled command, axis-by-command products
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_sq[i] = SQ_W'(r6_vm[i]) * SQ_W'(r6_vm[i]);
            for (int j = 0; j < 3; j++) begin
                n7_p[i][j] = P_W'(r6_a[i]) * P_W'(r6_vs[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: radicand, dot product and cross product
    // ------------------------------------------------------------------
    always_comb begin
        n8_rad      = RAD_W'(r7_sq[0]) + RAD_W'(r7_sq[1]) + RAD_W'(r7_sq[2]);
        n8_side.dot = Q_W'(r7_p[0][0]) + Q_W'(r7_p[1][1]) + Q_W'(r7_p[2][2]);
        n8_side.q1  = Q_W'(r7_p[1][2]) - Q_W'(r7_p[2][1]);
        n8_side.q2  = Q_W'(r7_p[2][0]) - Q_W'(r7_p[0][2]);
        n8_side.q3  = Q_W'(r7_p[0][1]) - Q_W'(r7_p[1][0]);
        n8_side.sh  = r7_sh;
    end

    // Root of the scaled command norm
    pdpat_sqrt #(
        .SIDE_W (SIDE1_W)
    ) u_sqrt_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r8_vld),
        .i_rad   (r8_rad),
        .i_side  (r8_side),
        .o_valid (s1_vld),
        .o_root  (s1_root),
        .o_side  (s1_side_v)
    );

    assign s1_side = pdpat_pkg::t_side1'(s1_side_v);

    // ------------------------------------------------------------------
    // Stage 9: scalar part of the raw quaternion, root times mass
    // ------------------------------------------------------------------
    always_comb begin
        n9_q[0] = s1_side.dot + $signed(Q_W'({s1_root, {pdpat_pkg::N_SHIFT{1'b0}}}));
        n9_q[1] = s1_side.q1;
        n9_q[2] = s1_side.q2;
        n9_q[3] = s1_side.q3;
        n9_prod = PROD_W'(s1_root) * PROD_W'(pdpat_pkg::MASS_Q16);
    end

    // ------------------------------------------------------------------
    // Stage 10: thrust to Q16.16 rounded half up and saturated
    // ------------------------------------------------------------------
    always_comb begin
        logic [SH_W-1:0]   rsh;
        logic [PROD_W:0]   sum;
        logic [PROD_W:0]   full;
        rsh  = SH_W'(pdpat_pkg::U_FRAC) - r9_sh;
        sum  = (PROD_W + 1)'(r9_prod) + ((PROD_W + 1)'(1) << (rsh - SH_W'(1)));
        full = sum >> rsh;
        n10_thr = (|full[PROD_W:THR_W]) ? {THR_W{1'b1}} : full[THR_W-1:0];
        for (int i = 0; i < 4; i++) begin
            n10_neg[i] = r9_q[i][Q_W-1];
            n10_qm[i]  = r9_q[i][Q_W-1] ? QM_W'(-r9_q[i]) : QM_W'(r9_q[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: block-scale shift for the quaternion
    // ------------------------------------------------------------------
    always_comb begin
        logic [QM_W-1:0] or_q;
        or_q   = r10_qm[0] | r10_qm[1] | r10_qm[2] | r10_qm[3];
        n11_sh = '0;
        for (int b = VM_W; b < QM_W; b++) begin
            if (or_q[b]) n11_sh = SH_W'(b - VM_W + 1);
        end
    end

    // ------------------------------------------------------------------
    // Stages 12 to 14: scale, square, sum
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n12_qs[i] = VM_W'(r11_qm[i] >> r11_sh);
            n13_sq[i] = SQ_W'(r12_qs[i]) * SQ_W'(r12_qs[i]);
            n14_side.qm[i] = r13_qs[i];
        end
        n14_rad = RAD_W'(r13_sq[0]) + RAD_W'(r13_sq[1])
                + RAD_W'(r13_sq[2]) + RAD_W'(r13_sq[3]);
        n14_side.neg = r13_neg;
        n14_side.thr = r13_thr;
    end

    // Root of the quaternion norm
    pdpat_sqrt #(
        .SIDE_W (SIDE2_W)
    ) u_sqrt_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r14_vld),
        .i_rad   (r14_rad),
        .i_side  (r14_side),
        .o_valid (s2_vld),
        .o_root  (s2_root),
        .o_side  (s2_side_v)
    );

    assign s2_side = pdpat_pkg::t_side2'(s2_side_v);

    // ------------------------------------------------------------------
    // Stage 15: dividends m*2^14 + N/2
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n15_d[i] = DIV_W'({s2_side.qm[i], {pdpat_pkg::FRAC_Q{1'b0}}})
                     + DIV_W'(s2_root >> 1);
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, four lanes
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            c_drem[0][i] = r15_d[i];
            c_dquo[0][i] = '0;
        end
        for (int j = 0; j < DSTG; j++) begin
            for (int i = 0; i < 4; i++) begin
                c_drem[j+1][i] = r_drem[j][i];
                c_dquo[j+1][i] = r_dquo[j][i];
            end
        end
    end

    always_comb begin
        logic [DIV_W-1:0] dd;
        logic [RT_W-1:0]  nn;
        for (int j = 0; j < DSTG; j++) begin
            nn = (j == 0) ? r15_nn : r_dnn[(j == 0) ? 0 : j - 1];
            dd = DIV_W'(nn) << (DSTG - 1 - j);
            for (int i = 0; i < 4; i++) begin
                n_dquo[j][i] = c_dquo[j][i];
                if (c_drem[j][i] >= dd) begin
                    n_drem[j][i] = c_drem[j][i] - dd;
                    n_dquo[j][i][DSTG-1-j] = 1'b1;
                end else begin
                    n_drem[j][i] = c_drem[j][i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: apply signs, zero norm gives a zero quaternion
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [ATT_W-1:0] d [0:3];
        for (int i = 0; i < 4; i++) begin
            d[i] = $signed(ATT_W'(c_dquo[DSTG][i]));
            if (r_dnn[DSTG-1] == '0) begin
                d[i] = '0;
            end else if (r_dneg[DSTG-1][i]) begin
                d[i] = -d[i];
            end
        end
        n_out.des_w        = d[0];
        n_out.des_x        = d[1];
        n_out.des_y        = d[2];
        n_out.des_z        = d[3];
        n_out.thrust_force = r_dthr[DSTG-1];
    end

    // ------------------------------------------------------------------
    // Advance valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            r13_vld <= 1'b0;
            r14_vld <= 1'b0;
            r15_vld <= 1'b0;
            r_dvld  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r1_vld  <= start && !busy;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= s1_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
            r13_vld <= r12_vld;
            r14_vld <= r13_vld;
            r15_vld <= s2_vld;
            r_dvld  <= {r_dvld[DSTG-2:0], r15_vld};
            r_ovld  <= r_dvld[DSTG-1];
        end
    end

    // ------------------------------------------------------------------
    // Advance payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r1_ep <= n1_ep;
        r1_ev <= n1_ev;
        r1_pxz <= n1_pxz;
        r1_pwy <= n1_pwy;
        r1_pyz <= n1_pyz;
        r1_pwx <= n1_pwx;
        r1_pxx <= n1_pxx;
        r1_pyy <= n1_pyy;

        r2_pk <= n2_pk;
        r2_dk <= n2_dk;
        r2_a  <= n2_a;

        r3_u <= n3_u;
        r3_a <= r2_a;

        r4_m   <= n4_m;
        r4_neg <= n4_neg;
        r4_a   <= r3_a;

        r5_sh  <= n5_sh;
        r5_m   <= r4_m;
        r5_neg <= r4_neg;
        r5_a   <= r4_a;

        r6_vm <= n6_vm;
        r6_vs <= n6_vs;
        r6_sh <= r5_sh;
        r6_a  <= r5_a;

        r7_sq <= n7_sq;
        r7_p  <= n7_p;
        r7_sh <= r6_sh;

        r8_rad  <= n8_rad;
        r8_side <= n8_side;

        r9_q    <= n9_q;
        r9_prod <= n9_prod;
        r9_sh   <= s1_side.sh;

        r10_thr <= n10_thr;
        r10_qm  <= n10_qm;
        r10_neg <= n10_neg;

        r11_sh  <= n11_sh;
        r11_qm  <= r10_qm;
        r11_neg <= r10_neg;
        r11_thr <= r10_thr;

        r12_qs  <= n12_qs;
        r12_neg <= r11_neg;
        r12_thr <= r11_thr;

        r13_sq  <= n13_sq;
        r13_qs  <= r12_qs;
        r13_neg <= r12_neg;
        r13_thr <= r12_thr;

        r14_rad  <= n14_rad;
        r14_side <= n14_side;

        r15_d   <= n15_d;
        r15_nn  <= s2_root;
        r15_neg <= s2_side.neg;
        r15_thr <= s2_side.thr;

        r_drem    <= n_drem;
        r_dquo    <= n_dquo;
        r_dnn[0]  <= r15_nn;
        r_dneg[0] <= r15_neg;
        r_dthr[0] <= r15_thr;
        for (int j = 1; j < DSTG; j++) begin
            r_dnn[j]  <= r_dnn[j-1];
            r_dneg[j] <= r_dneg[j-1];
            r_dthr[j] <= r_dthr[j-1];
        end

        r_out <= n_out;
    end

    assign o_valid = r_ovld;
    assign o_out   = r_out;

endmodule

FILE: sv/pdpat_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpat_sqrt
// Pipelined integer square root, one root bit per stage, with side data that
// travels in step with the radicand.
// ----------------------------------------------------------------------------
module pdpat_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [pdpat_pkg::SQ_IN_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [pdpat_pkg::SQ_OUT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int N  = pdpat_pkg::SQRT_STG;
    localparam int RW = pdpat_pkg::SQ_IN_W + 1;

    logic [N-1:0]      r_vld;
    logic [RW-1:0]     r_rem  [0:N-1];
    logic [RW-1:0]     r_root [0:N-1];
    logic [SIDE_W-1:0] r_side [0:N-1];

    logic [RW-1:0]     c_rem  [0:N];
    logic [RW-1:0]     c_root [0:N];
    logic [RW-1:0]     n_rem  [0:N-1];
    logic [RW-1:0]     n_root [0:N-1];

    // Stage inputs: the radicand for the first stage, the previous stage after
    always_comb begin
        c_rem[0]  = RW'(i_rad);
        c_root[0] = '0;
        for (int j = 0; j < N; j++) begin
            c_rem[j+1]  = r_rem[j];
            c_root[j+1] = r_root[j];
        end
    end

    // Try one root bit per stage, highest first
    always_comb begin
        logic [RW-1:0] bitv;
        logic [RW-1:0] trial;
        for (int j = 0; j < N; j++) begin
            bitv  = RW'(1) << (2 * (N - 1 - j));
            trial = c_root[j] + bitv;
            if (c_rem[j] >= trial) begin
                n_rem[j]  = c_rem[j] - trial;
                n_root[j] = (c_root[j] >> 1) + bitv;
            end else begin
                n_rem[j]  = c_rem[j];
                n_root[j] = c_root[j] >> 1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            r_rem[j]  <= n_rem[j];
            r_root[j] <= n_root[j];
        end
        r_side[0] <= i_side;
        for (int j = 1; j < N; j++) begin
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1][pdpat_pkg::SQ_OUT_W-1:0];
    assign o_side  = r_side[N-1];

endmodule

FILE: sv/pdpat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpat_checker
// Port-level checks on the attitude/thrust pipeline: fixed latency, no
// spurious results, quaternion range, reset flush.
// ----------------------------------------------------------------------------
module pdpat_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input pdpat_pkg::t_out_beat o_out
);

    localparam int LAT = pdpat_pkg::PIPE_LAT;

    // Every accepted beat gives a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after accepted beat");

    // No result without a beat accepted the latency before
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without accepted beat");

    // Normalized quaternion components stay within unit range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.des_w <= pdpat_pkg::OUT_MAX && o_out.des_w >= -pdpat_pkg::OUT_MAX &&
                     o_out.des_x <= pdpat_pkg::OUT_MAX && o_out.des_x >= -pdpat_pkg::OUT_MAX &&
                     o_out.des_y <= pdpat_pkg::OUT_MAX && o_out.des_y >= -pdpat_pkg::OUT_MAX &&
                     o_out.des_z <= pdpat_pkg::OUT_MAX && o_out.des_z >= -pdpat_pkg::OUT_MAX))
        else $error("quaternion component out of range");

    // Reset flushes the pipeline
    a_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind pd_position_to_attitude_thrust pdpat_checker u_pdpat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);

FILE: test/pd_position_to_attitude_thrust_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_position_to_attitude_thrust_tb
// Drives position, velocity and attitude beats into the PD attitude/thrust
// pipeline with random gaps, computes each expected desired quaternion and
// thrust with a local fixed-point model, and checks every result in order.
// ----------------------------------------------------------------------------
module pd_position_to_attitude_thrust_tb;
    import pdpat_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_beat             i_in;
    logic                 o_valid;
    t_out_beat            o_out;
    logic                 i_cfg_we;
    logic [CFG_A_W-1:0]   i_cfg_addr;
    logic [CFG_D_W-1:0]   i_cfg_data;

    // Local copy of the gains and references
    logic [15:0]          kp_q88;
    logic [15:0]          kd_q88;
    logic signed [31:0]   ref_pos [3];
    logic signed [31:0]   ref_vel [3];

    t_out_beat            pending_cmds[$];
    int                   err_cnt;
    bit                   allow_gaps;

    pd_position_to_attitude_thrust u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Magnitude of a signed 64-bit value
    function automatic longint unsigned mag64(input longint x);
        return (x < 0) ? longint'(0) - x : x;
    endfunction

    // Integer square root, floor
    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Shift until every magnitude is below 2^30, truncating toward zero
    function automatic int norm_shift(input longint v [4], input int cnt);
        int s;
        bit big;
        s = 0;
        big = 1'b1;
        while (big && s < 63) begin
            big = 1'b0;
            for (int i = 0; i < cnt; i++)
                if ((mag64(v[i]) >> s) >= (64'd1 << 30)) big = 1'b1;
            if (big) s++;
        end
        return s;
    endfunction

    function automatic longint shrink(input longint x, input int s);
        longint m;
        m = longint'(mag64(x) >> s);
        return (x < 0) ? -m : m;
    endfunction

    // Round half up to Q.20 from Q.28
    function automatic longint axis_round(input longint x);
        return ((x + (64'sd1 << 40) + 128) >>> 8) - ((64'sd1 << 40) >>> 8);
    endfunction

    // Desired attitude and thrust for one beat under the current gains
    function automatic t_out_beat attitude_thrust(input t_in_beat b);
        longint          u [4];
        longint          v [4];
        longint          q [4];
        longint          qs [4];
        longint          ax [3];
        longint          w, x, y, z, r;
        longint unsigned n, prod, thr, nn, rq;
        int              s, l;
        t_out_beat       o;
        u[0] = -(longint'(kp_q88) * (longint'(b.pos_x) - ref_pos[0]))
               - longint'(kd_q88) * (longint'(b.vel_x) - ref_vel[0]);
        u[1] = -(longint'(kp_q88) * (longint'(b.pos_y) - ref_pos[1]))
               - longint'(kd_q88) * (longint'(b.vel_y) - ref_vel[1]);
        u[2] = -(longint'(kp_q88) * (longint'(b.pos_z) - ref_pos[2]))
               - longint'(kd_q88) * (longint'(b.vel_z) - ref_vel[2]) - 164416717;
        u[3] = 0;
        s = norm_shift(u, 3);
        for (int i = 0; i < 3; i++) v[i] = shrink(u[i], s);
        n = root64(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        prod = n * 187171;
        if (s >= 24) begin
            l = s - 24;
            thr = (l >= 32 || prod > (64'hFFFF_FFFF >> l)) ? 64'hFFFF_FFFF : (prod << l);
            if (prod == 0) thr = 0;
        end else begin
            l = 24 - s;
            thr = (prod + (64'd1 << (l - 1))) >> l;
            if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
        end
        w = b.att_w; x = b.att_x; y = b.att_y; z = b.att_z;
        ax[0] = axis_round(-2 * (x * z + w * y));
        ax[1] = axis_round(-2 * (y * z - w * x));
        ax[2] = axis_round(2 * (x * x + y * y) - (64'sd1 << 28));
        q[0] = ax[0] * v[0] + ax[1] * v[1] + ax[2] * v[2] + longint'(n << 20);
        q[1] = ax[1] * v[2] - ax[2] * v[1];
        q[2] = ax[2] * v[0] - ax[0] * v[2];
        q[3] = ax[0] * v[1] - ax[1] * v[0];
        s = norm_shift(q, 4);
        nn = 0;
        for (int i = 0; i < 4; i++) begin
            qs[i] = shrink(q[i], s);
            nn += qs[i] * qs[i];
        end
        nn = root64(nn);
        for (int i = 0; i < 4; i++) begin
            rq = (nn != 0) ? (mag64(qs[i]) * 16384 + nn / 2) / nn : 0;
            r = (qs[i] < 0) ? -longint'(rq) : longint'(rq);
            qs[i] = r;
        end
        o.des_w = qs[0][15:0];
        o.des_x = qs[1][15:0];
        o.des_y = qs[2][15:0];
        o.des_z = qs[3][15:0];
        o.thrust_force = thr[31:0];
        return o;
    endfunction

    // Random burst of idle cycles on the input side
    task automatic idle_gap();
        int n;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Send one beat and record its expected result; start stays high so the
    // next beat can follow without a gap
    task automatic send_beat(input t_in_beat b);
        idle_gap();
        start <= 1'b1;
        i_in  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_cmds.push_back(attitude_thrust(b));
        @(negedge i_clk);
    endtask

    // Wait for the pipeline to drain, then let it settle
    task automatic drain();
        start <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 10) @(negedge i_clk);
    endtask

    // Write one register while idle
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_KP_GAIN:   kp_q88 = d[15:0];
            CFG_KD_GAIN:   kd_q88 = d[15:0];
            CFG_REF_POS_X: ref_pos[0] = d;
            CFG_REF_POS_Y: ref_pos[1] = d;
            CFG_REF_POS_Z: ref_pos[2] = d;
            CFG_REF_VEL_X: ref_vel[0] = d;
            CFG_REF_VEL_Y: ref_vel[1] = d;
            CFG_REF_VEL_Z: ref_vel[2] = d;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic [15:0] rand_att();
        case ($urandom_range(0, 7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        b.pos_x = rand_pos(); b.pos_y = rand_pos(); b.pos_z = rand_pos();
        b.vel_x = rand_pos(); b.vel_y = rand_pos(); b.vel_z = rand_pos();
        b.att_w = rand_att(); b.att_x = rand_att();
        b.att_y = rand_att(); b.att_z = rand_att();
        return b;
    endfunction

    // Hover, extremes, zero quaternion norm and thrust saturation
    task automatic test_directed();
        t_in_beat b;
        b = '0;
        b.att_w = 16'sd16384;
        send_beat(b);
        b = '0;
        send_beat(b);
        b.att_x = 16'sd16384;
        send_beat(b);
        // Upside-down attitude with command straight down, along the thrust axis
        b = '0; b.att_x = 16'sd16384; b.pos_z = 32'sh8000_0000;
        send_beat(b);
        for (int i = 0; i < 4; i++) begin
            b = {{6{(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF)}}, 64'h0};
            b.att_w = i[1] ? 16'h8000 : 16'h7FFF;
            b.att_x = i[1] ? 16'h7FFF : 16'h8000;
            b.att_y = 16'hFFFF; b.att_z = 16'h0000;
            send_beat(b);
        end
        b = '0; b.att_w = -16'sd16384; b.pos_x = 32'sh0001_0000;
        b.vel_y = -32'sh0002_0000;
        send_beat(b);
        for (int i = 0; i < 8; i++) send_beat(rand_beat());
        drain();
    endtask

    // Gains and references at extremes, then random settings
    task automatic test_config_sweep();
        write_reg(CFG_KP_GAIN, 32'hFFFF);
        write_reg(CFG_KD_GAIN, 32'hFFFF);
        for (int i = 0; i < 15; i++) send_beat(rand_beat());
        drain();
        write_reg(CFG_KP_GAIN, 32'h0);
        write_reg(CFG_KD_GAIN, 32'h0);
        for (int i = 0; i < 10; i++) send_beat(rand_beat());
        drain();
        write_reg(CFG_REF_POS_X, 32'h8000_0000);
        write_reg(CFG_REF_POS_Y, 32'h7FFF_FFFF);
        write_reg(CFG_REF_POS_Z, 32'h8000_0000);
        write_reg(CFG_REF_VEL_X, 32'h7FFF_FFFF);
        write_reg(CFG_REF_VEL_Y, 32'h8000_0000);
        write_reg(CFG_REF_VEL_Z, 32'h7FFF_FFFF);
        write_reg(CFG_KP_GAIN, 32'hFFFF);
        write_reg(CFG_KD_GAIN, 32'h1);
        for (int i = 0; i < 30; i++) send_beat(rand_beat());
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_KP_GAIN, $urandom_range(0, 2000));
            write_reg(CFG_KD_GAIN, $urandom);
            write_reg(t_cfg_idx'(CFG_REF_POS_X + $urandom_range(0, 5)), rand_pos());
            for (int i = 0; i < 150; i++) send_beat(rand_beat());
            drain();
        end
    endtask

    // Back to reset gains and zero references, random beats with gaps, then without gaps
    task automatic test_back_to_back();
        write_reg(CFG_KP_GAIN, KP_RST);
        write_reg(CFG_KD_GAIN, KD_RST);
        for (int i = 0; i < 3; i++) begin
            write_reg(t_cfg_idx'(CFG_REF_POS_X + i), 32'h0);
            write_reg(t_cfg_idx'(CFG_REF_VEL_X + i), 32'h0);
        end
        for (int i = 0; i < 500; i++) send_beat(rand_beat());
        allow_gaps = 1'b0;
        for (int i = 0; i < 300; i++) send_beat(rand_beat());
        drain();
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && o_valid) begin
            if (pending_cmds.size() == 0) begin
                $error("result beat with no expectation waiting");
                err_cnt++;
            end else begin
                e = pending_cmds.pop_front();
                if (o_out.des_w !== e.des_w) begin
                    $error("des_w exp %0d got %0d", e.des_w, o_out.des_w); err_cnt++;
                end
                if (o_out.des_x !== e.des_x) begin
                    $error("des_x exp %0d got %0d", e.des_x, o_out.des_x); err_cnt++;
                end
                if (o_out.des_y !== e.des_y) begin
                    $error("des_y exp %0d got %0d", e.des_y, o_out.des_y); err_cnt++;
                end
                if (o_out.des_z !== e.des_z) begin
                    $error("des_z exp %0d got %0d", e.des_z, o_out.des_z); err_cnt++;
                end
                if (o_out.thrust_force !== e.thrust_force) begin
                    $error("thrust_force exp %0d got %0d", e.thrust_force,
                           o_out.thrust_force);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        err_cnt    = 0;
        allow_gaps = 1'b1;
        start      = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        kp_q88     = KP_RST;
        kd_q88     = KD_RST;
        for (int i = 0; i < 3; i++) begin
            ref_pos[i] = '0;
            ref_vel[i] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_sweep();
        test_back_to_back();
        if (pending_cmds.size() != 0) begin
            $error("%0d expected results never arrived", pending_cmds.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/pdpat_pkg.sv
sv/pdpat_sqrt.sv
sv/pd_position_to_attitude_thrust.sv
sv/pdpat_checker.sv
test/pd_position_to_attitude_thrust_tb.sv
